// ===== rtl/gamepad_teleop_mapper_macros.svh =====
// assertion macros for the gamepad teleop mapper
// expects a clock named clock and an active-high reset named reset in scope
`ifndef GAMEPAD_TELEOP_MAPPER_MACROS_SVH
`define GAMEPAD_TELEOP_MAPPER_MACROS_SVH

// condition implies property in the same cycle
`define GTM_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// condition implies property in the next cycle
`define GTM_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/gtm_pkg.sv =====
// shared constants and codes for the gamepad teleop mapper
// no dependencies
package gtm_pkg;

   localparam int AXIS_BITS_DEF = 16;
   localparam int TIME_BITS_DEF = 48;

   localparam int FACTOR_BITS = 16;
   localparam int FRAC_BITS   = 15;
   localparam int FSUM_BITS   = FACTOR_BITS + 3;
   localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = FACTOR_BITS'(32768);

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam int DEBOUNCE_BITS  = 32;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = DEBOUNCE_BITS'(200000);
   localparam logic [FACTOR_BITS-1:0]   STEP_RESET     = FACTOR_BITS'(3277);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP     = 1'b1;

   localparam int NUM_BTN  = 4;
   localparam int BTN_A     = 0;
   localparam int BTN_START = 1;
   localparam int BTN_LEFT  = 2;
   localparam int BTN_RIGHT = 3;

   localparam int NUM_AXES = 6;

   typedef logic [1:0] code_type;

   localparam code_type GRIP_NONE  = 2'd0;
   localparam code_type GRIP_OPEN  = 2'd1;
   localparam code_type GRIP_CLOSE = 2'd2;

   localparam code_type LEARN_NONE = 2'd0;
   localparam code_type LEARN_OFF  = 2'd1;
   localparam code_type LEARN_ON   = 2'd2;

endpackage

// ===== rtl/gamepad_teleop_mapper.sv =====
// gamepad teleop mapper top level: debounce, speed factor, axis scaling
// depends on gtm_pkg and gamepad_teleop_mapper_macros.svh
`include "gamepad_teleop_mapper_macros.svh"

// Takes one gamepad request per clock cycle while req_ready is high and returns one result
// per request, in order. A request passes three register stages: the input register, the
// decision register (button lockouts, speed factor, gripper and learning toggles, updated as
// the request leaves the input register) and the result register after the six axis
// multipliers, which drives rsp_valid. The stages hold while rsp_ready is low and the
// block keeps accepting until all three are full. Registers are written through the csr
// port, always ready, only while the block is idle, a user rule the block does not enforce.
module gamepad_teleop_mapper #(
   parameter int AXIS_BITS = gtm_pkg::AXIS_BITS_DEF,
   parameter int TIME_BITS = gtm_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gtm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gtm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [TIME_BITS-1:0]                 req_now_time,
   input  logic                                 req_press_a,
   input  logic                                 req_press_start,
   input  logic                                 req_press_left_shoulder,
   input  logic                                 req_press_right_shoulder,
   input  logic signed [AXIS_BITS-1:0]          req_right_stick_vertical,
   input  logic signed [AXIS_BITS-1:0]          req_left_stick_horizontal,
   input  logic signed [AXIS_BITS-1:0]          req_left_stick_vertical,
   input  logic signed [AXIS_BITS-1:0]          req_pad_vertical,
   input  logic signed [AXIS_BITS-1:0]          req_pad_horizontal,
   input  logic signed [AXIS_BITS-1:0]          req_right_stick_horizontal,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [AXIS_BITS-1:0]          rsp_linear_x,
   output logic signed [AXIS_BITS-1:0]          rsp_linear_y,
   output logic signed [AXIS_BITS-1:0]          rsp_linear_z,
   output logic signed [AXIS_BITS-1:0]          rsp_angular_x,
   output logic signed [AXIS_BITS-1:0]          rsp_angular_y,
   output logic signed [AXIS_BITS-1:0]          rsp_angular_z,
   output logic [1:0]                           rsp_gripper_command,
   output logic [1:0]                           rsp_learning_request,
   output logic [gtm_pkg::FACTOR_BITS-1:0]      rsp_speed_factor_now
);
   import gtm_pkg::*;

   localparam int PROD_BITS = AXIS_BITS + FACTOR_BITS + 1;

   // configuration
   logic [DEBOUNCE_BITS-1:0] debounce_ff;
   logic [FACTOR_BITS-1:0]   step_ff;

   // pipeline control
   logic a_valid_ff, b_valid_ff, r_valid_ff;
   logic a_adv, b_adv, req_load;

   // input stage
   logic [TIME_BITS-1:0]                a_now_ff;
   logic [NUM_BTN-1:0]                  a_press_ff;
   logic [NUM_AXES-1:0][AXIS_BITS-1:0]  a_axis_ff;

   // decision stage
   logic [NUM_AXES-1:0][AXIS_BITS-1:0]  b_axis_ff;
   logic [FACTOR_BITS-1:0]              b_factor_ff;
   code_type                            b_grip_ff;
   code_type                            b_learn_ff;

   // result stage
   logic [NUM_AXES-1:0][AXIS_BITS-1:0]  r_axis_ff;
   logic [FACTOR_BITS-1:0]              r_factor_ff;
   code_type                            r_grip_ff;
   code_type                            r_learn_ff;

   // persistent state
   logic [NUM_BTN-1:0][TIME_BITS-1:0]   deadline_ff, deadline_in;
   logic [FACTOR_BITS-1:0]              speed_factor_ff, speed_factor_in;
   logic                                gripper_opened_ff, gripper_opened_in;
   logic                                learning_on_ff, learning_on_in;

   logic [NUM_BTN-1:0]                  accepted;
   logic [TIME_BITS:0]                  dl_sum;
   logic [TIME_BITS-1:0]                dl_next;
   logic signed [FSUM_BITS-1:0]         f_sum;
   code_type                            grip_code, learn_code;
   logic signed [PROD_BITS-1:0]         prod [NUM_AXES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         step_ff     <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            CSR_STEP:     step_ff     <= csr_wdata[FACTOR_BITS-1:0];
            default:      ;
         endcase
      end
   end

   // flow control
   assign b_adv     = b_valid_ff && (!r_valid_ff || rsp_ready);
   assign a_adv     = a_valid_ff && (!b_valid_ff || b_adv);
   assign req_ready = !a_valid_ff || a_adv;
   assign req_load  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            a_valid_ff <= req_valid;
         end
         if (!b_valid_ff || b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
         if (!r_valid_ff || rsp_ready) begin
            r_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         a_now_ff              <= req_now_time;
         a_press_ff[BTN_A]     <= req_press_a;
         a_press_ff[BTN_START] <= req_press_start;
         a_press_ff[BTN_LEFT]  <= req_press_left_shoulder;
         a_press_ff[BTN_RIGHT] <= req_press_right_shoulder;
         a_axis_ff[0]          <= req_right_stick_vertical;
         a_axis_ff[1]          <= req_left_stick_horizontal;
         a_axis_ff[2]          <= req_left_stick_vertical;
         a_axis_ff[3]          <= req_pad_vertical;
         a_axis_ff[4]          <= req_pad_horizontal;
         a_axis_ff[5]          <= req_right_stick_horizontal;
      end
   end

   // button lockout and state update
   assign dl_sum  = {1'b0, a_now_ff} + (TIME_BITS+1)'(debounce_ff);
   assign dl_next = dl_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dl_sum[TIME_BITS-1:0];

   always_comb begin
      for (int i = 0; i < NUM_BTN; i++) begin
         accepted[i]    = a_press_ff[i] && (a_now_ff > deadline_ff[i]);
         deadline_in[i] = accepted[i] ? dl_next : deadline_ff[i];
      end
   end

   always_comb begin
      f_sum = FSUM_BITS'(speed_factor_ff);
      if (accepted[BTN_RIGHT]) begin
         f_sum = f_sum + FSUM_BITS'(step_ff);
      end
      if (accepted[BTN_LEFT]) begin
         f_sum = f_sum - FSUM_BITS'(step_ff);
      end
      if (f_sum[FSUM_BITS-1]) begin
         speed_factor_in = '0;
      end else if (f_sum > signed'(FSUM_BITS'(FACTOR_ONE))) begin
         speed_factor_in = FACTOR_ONE;
      end else begin
         speed_factor_in = f_sum[FACTOR_BITS-1:0];
      end
   end

   always_comb begin
      gripper_opened_in = gripper_opened_ff ^ accepted[BTN_A];
      learning_on_in    = learning_on_ff ^ accepted[BTN_START];
      grip_code         = GRIP_NONE;
      learn_code        = LEARN_NONE;
      if (accepted[BTN_A]) begin
         grip_code = gripper_opened_in ? GRIP_OPEN : GRIP_CLOSE;
      end
      if (accepted[BTN_START]) begin
         learn_code = learning_on_in ? LEARN_ON : LEARN_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff       <= '0;
         speed_factor_ff   <= '0;
         gripper_opened_ff <= 1'b0;
         learning_on_ff    <= 1'b0;
      end else if (a_adv) begin
         deadline_ff       <= deadline_in;
         speed_factor_ff   <= speed_factor_in;
         gripper_opened_ff <= gripper_opened_in;
         learning_on_ff    <= learning_on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_axis_ff   <= a_axis_ff;
         b_factor_ff <= speed_factor_in;
         b_grip_ff   <= grip_code;
         b_learn_ff  <= learn_code;
      end
   end

   // axis scaling, arithmetic shift by the fraction width
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         prod[i] = signed'(b_axis_ff[i]) * signed'({1'b0, b_factor_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            r_axis_ff[i] <= prod[i][FRAC_BITS +: AXIS_BITS];
         end
         r_factor_ff <= b_factor_ff;
         r_grip_ff   <= b_grip_ff;
         r_learn_ff  <= b_learn_ff;
      end
   end

   assign rsp_valid            = r_valid_ff;
   assign rsp_linear_x         = r_axis_ff[0];
   assign rsp_linear_y         = r_axis_ff[1];
   assign rsp_linear_z         = r_axis_ff[2];
   assign rsp_angular_x        = r_axis_ff[3];
   assign rsp_angular_y        = r_axis_ff[4];
   assign rsp_angular_z        = r_axis_ff[5];
   assign rsp_gripper_command  = r_grip_ff;
   assign rsp_learning_request = r_learn_ff;
   assign rsp_speed_factor_now = r_factor_ff;

   `GTM_ASSERT_IMP(a_factor_bound, 1'b1, speed_factor_ff <= FACTOR_ONE, "speed factor above one")
   `GTM_ASSERT_NXT(a_grip_toggle, a_adv && accepted[BTN_A],
      gripper_opened_ff != $past(gripper_opened_ff), "gripper did not toggle")
   `GTM_ASSERT_NXT(a_deadline_moves, a_adv && accepted[BTN_START],
      deadline_ff[BTN_START] >= $past(a_now_ff), "deadline behind time")
   `GTM_ASSERT_NXT(a_req_lands, req_load, a_valid_ff, "accepted request lost")
   `GTM_ASSERT_IMP(a_grip_code, r_valid_ff,
      (r_grip_ff == GRIP_NONE || r_grip_ff == GRIP_OPEN || r_grip_ff == GRIP_CLOSE),
      "invalid gripper code")

endmodule
